>>> rtl/twm_pkg.sv
`default_nettype none

package twm_pkg;

    typedef logic [7:0] char_t;
    typedef logic [3:0] sep_mask_t;

    localparam int unsigned NUM_SEPS = 4;

    // Wildcard codes
    localparam char_t WILD_FINAL = 8'h23;   // '#'
    localparam char_t WILD_INFIX = 8'h2B;   // '+'

    // Register indexes on the configuration port
    localparam logic [1:0] REG_SEP_CHARS   = 2'd0;
    localparam logic [1:0] REG_SEP_COUNT   = 2'd1;
    localparam logic [1:0] REG_REJECT_WILD = 2'd2;

    function automatic logic is_wild(input char_t c);
        return (c == WILD_FINAL) || (c == WILD_INFIX);
    endfunction

    // Mark the packed separator bytes in use: the first sep_count bytes,
    // cut at the first zero byte.
    function automatic sep_mask_t sep_mask(input logic [31:0] chars, input logic [2:0] count);
        sep_mask_t  mask;
        logic       run;
        logic [2:0] n;
        n    = (count > 3'd4) ? 3'd4 : count;
        run  = 1'b1;
        mask = '0;
        for (int k = 0; k < NUM_SEPS; k++)
        begin
            run     = run && (3'(k) < n) && (chars[8*k +: 8] != 8'h00);
            mask[k] = run;
        end
        return mask;
    endfunction

    function automatic logic is_sep(input char_t c, input logic [31:0] chars,
                                    input sep_mask_t mask);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < NUM_SEPS; k++)
        begin
            hit = hit || (mask[k] && (chars[8*k +: 8] == c));
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

>>> rtl/twm_pub_buffer.sv
`default_nettype none

// Publication character store: one write port, one registered read port.
module twm_pub_buffer
    import twm_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire char_t               wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output char_t                    rdata
);

    char_t mem [DEPTH];
    char_t rdata_reg;

    // Write and read the store
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/topic_wildcard_matcher.sv
`default_nettype none

// Topic wildcard matcher.
// Load a publication topic one character per transaction (op=0, last on its
// final character), then stream a subscription filter (op=1). A transaction
// is taken when start is high and busy is low. The final filter character
// yields one result: status (1 = invalid topic, filter or separator set) and
// match, shown on result_valid for exactly one cycle; the receiver cannot
// stall it. The publication stays loaded for further filters.
// A publication character is taken without leaving the idle state. A literal
// filter character is compared in an evaluation state, as the buffer read is
// registered. A wildcard walks the publication segment it skips in a scan
// state, through the buffer's single read port, up to a separator or the
// end. A filter character after a mismatch, an early match or the end of the
// publication skips both. The final filter character then enters a finishing
// state that forms the result, which appears the cycle after.
// Configuration writes (cfg_index, cfg_data) are always taken and must only
// be issued while the block is idle.
// Reset clears all control state and the configuration to its defaults
// (separators '.' and '/', wildcards allowed); the buffer content is not
// cleared and needs no clearing pass.
module topic_wildcard_matcher
    import twm_pkg::*;
#(
    parameter int MAX_LEN = 256
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    output logic       busy,
    input  wire        op,
    input  wire  [7:0] char_code,
    input  wire        last,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire  [1:0] cfg_index,
    input  wire [31:0] cfg_data,
    output logic       result_valid,
    output logic       status,
    output logic       match
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam logic [LW-1:0] MAX_LEN_L = LW'(MAX_LEN);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // Configuration
    logic [31:0] sep_chars_reg;
    logic [2:0]  sep_count_reg;
    logic        reject_wild_reg;
    sep_mask_t   smask;

    // Sequencer and matching state
    logic [1:0]    state_reg, state_next;
    logic [LW-1:0] pub_length_reg, pub_length_next;
    logic [LW-1:0] pub_cursor_reg, pub_cursor_next;
    logic [LW-1:0] scan_ptr_reg, scan_ptr_next;
    logic          pub_bad_reg, pub_bad_next;
    logic          pub_done_reg, pub_done_next;
    char_t         pub_last_reg, pub_last_next;
    char_t         sub_prev_char_reg, sub_prev_char_next;
    char_t         char_reg, char_next;
    logic          last_reg, last_next;
    logic          lit_reg, lit_next;
    logic          sub_started_reg, sub_started_next;
    logic          sub_has_wild_reg, sub_has_wild_next;
    logic          sub_bad_reg, sub_bad_next;
    logic          mismatch_seen_reg, mismatch_seen_next;
    logic          early_match_reg, early_match_next;
    logic          after_wild_reg, after_wild_next;
    logic          result_valid_reg, result_valid_next;
    logic          status_reg, status_next;
    logic          match_reg, match_next;

    // Buffer ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    char_t         mem_rdata;

    logic          accept;
    logic          literal;
    logic [LW-1:0] len_eff;
    logic [LW-1:0] ptr_inc;
    logic [LW-1:0] stop_at;
    logic          stop;
    logic          pub_ok;
    logic          bad;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign smask     = sep_mask(sep_chars_reg, sep_count_reg);

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign match        = match_reg;

    twm_pub_buffer #(
        .DEPTH (MAX_LEN)
    ) u_buffer (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (char_code),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_chars_reg   <= 32'd12078;
            sep_count_reg   <= 3'd2;
            reject_wild_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SEP_CHARS:   sep_chars_reg   <= cfg_data;
                REG_SEP_COUNT:   sep_count_reg   <= cfg_data[2:0];
                REG_REJECT_WILD: reject_wild_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next         = state_reg;
        pub_length_next    = pub_length_reg;
        pub_cursor_next    = pub_cursor_reg;
        scan_ptr_next      = scan_ptr_reg;
        pub_bad_next       = pub_bad_reg;
        pub_done_next      = pub_done_reg;
        pub_last_next      = pub_last_reg;
        sub_prev_char_next = sub_prev_char_reg;
        char_next          = char_reg;
        last_next          = last_reg;
        lit_next           = lit_reg;
        sub_started_next   = sub_started_reg;
        sub_has_wild_next  = sub_has_wild_reg;
        sub_bad_next       = sub_bad_reg;
        mismatch_seen_next = mismatch_seen_reg;
        early_match_next   = early_match_reg;
        after_wild_next    = after_wild_reg;
        result_valid_next  = 1'b0;
        status_next        = status_reg;
        match_next         = match_reg;

        mem_we    = 1'b0;
        len_eff   = pub_done_reg ? '0 : pub_length_reg;
        mem_waddr = len_eff[AW-1:0];
        mem_raddr = pub_cursor_reg[AW-1:0];
        literal   = after_wild_reg || !is_wild(char_code);
        ptr_inc   = scan_ptr_reg + LW'(1);
        stop      = 1'b0;
        stop_at   = scan_ptr_reg;
        pub_ok    = (pub_length_reg != '0) && !pub_bad_reg &&
                    !is_sep(pub_last_reg, sep_chars_reg, smask);
        bad       = (smask == '0) || !pub_ok || sub_bad_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !op)
                begin
                    // Store a publication character, drop any filter in progress
                    pub_cursor_next    = '0;
                    sub_prev_char_next = '0;
                    sub_started_next   = 1'b0;
                    sub_has_wild_next  = 1'b0;
                    sub_bad_next       = 1'b0;
                    mismatch_seen_next = 1'b0;
                    early_match_next   = 1'b0;
                    after_wild_next    = 1'b0;
                    pub_bad_next       = (pub_done_reg ? 1'b0 : pub_bad_reg) ||
                                         is_wild(char_code);
                    if (len_eff < MAX_LEN_L)
                    begin
                        mem_we          = 1'b1;
                        pub_length_next = len_eff + LW'(1);
                        pub_last_next   = char_code;
                    end
                    else
                    begin
                        pub_length_next = len_eff;
                        pub_bad_next    = 1'b1;
                    end
                    pub_done_next = last;
                end
                else if (accept)
                begin
                    // Check filter rules for a subscription character
                    pub_done_next = 1'b1;
                    if (!literal)
                    begin
                        sub_has_wild_next = 1'b1;
                        if ((sub_started_reg &&
                             !is_sep(sub_prev_char_reg, sep_chars_reg, smask)) ||
                            (!last && char_code != WILD_INFIX))
                        begin
                            sub_bad_next = 1'b1;
                        end
                    end
                    else if ((after_wild_reg && !is_sep(char_code, sep_chars_reg, smask)) ||
                             (last && is_sep(char_code, sep_chars_reg, smask)))
                    begin
                        sub_bad_next = 1'b1;
                    end
                    after_wild_next    = !literal;
                    sub_prev_char_next = char_code;
                    sub_started_next   = 1'b1;
                    char_next          = char_code;
                    last_next          = last;
                    lit_next           = literal;
                    scan_ptr_next      = pub_cursor_reg;

                    // Start matching against the buffer
                    if (!mismatch_seen_reg && !early_match_reg)
                    begin
                        if (pub_cursor_reg >= pub_length_reg)
                        begin
                            mismatch_seen_next = 1'b1;
                            state_next         = last ? ST_FIN : ST_IDLE;
                        end
                        else
                        begin
                            state_next = literal ? ST_EVAL : ST_SCAN;
                        end
                    end
                    else
                    begin
                        state_next = last ? ST_FIN : ST_IDLE;
                    end
                end
            end

            ST_EVAL:
            begin
                // Compare a literal character with the buffer at the cursor
                if (mem_rdata != char_reg)
                begin
                    mismatch_seen_next = 1'b1;
                end
                else
                begin
                    pub_cursor_next = pub_cursor_reg + LW'(1);
                end
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end

            ST_SCAN:
            begin
                // Walk the publication segment until a separator or the end
                mem_raddr = ptr_inc[AW-1:0];
                if (is_sep(mem_rdata, sep_chars_reg, smask))
                begin
                    stop    = 1'b1;
                    stop_at = scan_ptr_reg;
                end
                else if (ptr_inc == pub_length_reg)
                begin
                    stop    = 1'b1;
                    stop_at = ptr_inc;
                end
                else
                begin
                    scan_ptr_next = ptr_inc;
                end
                if (stop)
                begin
                    if (stop_at != pub_cursor_reg)
                    begin
                        pub_cursor_next = stop_at;
                        if (last_reg && (char_reg == WILD_FINAL || stop_at == pub_length_reg))
                        begin
                            early_match_next = 1'b1;
                        end
                    end
                    state_next = last_reg ? ST_FIN : ST_IDLE;
                end
            end

            ST_FIN:
            begin
                // Form the result and clear the filter state
                result_valid_next = 1'b1;
                status_next       = bad;
                match_next        = !bad && !(reject_wild_reg && sub_has_wild_reg) &&
                                    (early_match_reg ||
                                     (!mismatch_seen_reg && lit_reg &&
                                      pub_cursor_reg == pub_length_reg));
                pub_cursor_next    = '0;
                sub_prev_char_next = '0;
                sub_started_next   = 1'b0;
                sub_has_wild_next  = 1'b0;
                sub_bad_next       = 1'b0;
                mismatch_seen_next = 1'b0;
                early_match_next   = 1'b0;
                after_wild_next    = 1'b0;
                state_next         = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            pub_length_reg    <= '0;
            pub_cursor_reg    <= '0;
            pub_bad_reg       <= 1'b0;
            pub_done_reg      <= 1'b0;
            sub_prev_char_reg <= '0;
            sub_started_reg   <= 1'b0;
            sub_has_wild_reg  <= 1'b0;
            sub_bad_reg       <= 1'b0;
            mismatch_seen_reg <= 1'b0;
            early_match_reg   <= 1'b0;
            after_wild_reg    <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            pub_length_reg    <= pub_length_next;
            pub_cursor_reg    <= pub_cursor_next;
            pub_bad_reg       <= pub_bad_next;
            pub_done_reg      <= pub_done_next;
            sub_prev_char_reg <= sub_prev_char_next;
            sub_started_reg   <= sub_started_next;
            sub_has_wild_reg  <= sub_has_wild_next;
            sub_bad_reg       <= sub_bad_next;
            mismatch_seen_reg <= mismatch_seen_next;
            early_match_reg   <= early_match_next;
            after_wild_reg    <= after_wild_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        scan_ptr_reg <= scan_ptr_next;
        pub_last_reg <= pub_last_next;
        char_reg     <= char_next;
        last_reg     <= last_next;
        lit_reg      <= lit_next;
        status_reg   <= status_next;
        match_reg    <= match_next;
    end

`ifndef SYNTHESIS
    a_result_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_FIN))
        else $error("result strobe without a finishing step");

    a_match_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && match) |-> !status)
        else $error("match reported with invalid status");

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pub_cursor_reg <= pub_length_reg) && (pub_length_reg <= MAX_LEN_L))
        else $error("cursor or length out of range");
`endif

endmodule

`default_nettype wire

>>> test/tb_topic_wildcard_matcher.sv
`timescale 1ns / 1ps

module tb_topic_wildcard_matcher;
    import twm_pkg::*;

    localparam int BUF_DEPTH = 256;
    localparam int PHASE_ITEMS = 12;

    typedef struct packed {
        logic status;
        logic match;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        op;
    logic [7:0]  char_code;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        result_valid;
    logic        status;
    logic        match;

    topic_wildcard_matcher #(
        .MAX_LEN(BUF_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .char_code(char_code),
        .last(last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .result_valid(result_valid),
        .status(status),
        .match(match)
    );

    // Expected verdicts, oldest first
    verdict_t pending_verdicts[$];
    verdict_t head_verdict;
    int       fail_count;
    int       items_sent;
    bit       no_idle;

    // Shadow copy of the configuration
    logic [31:0] shadow_seps;
    logic [2:0]  shadow_count;
    logic        shadow_reject;

    // Shadow copy of the matcher state
    char_t       topic_buf[BUF_DEPTH];
    int unsigned topic_len;
    int unsigned topic_pos;
    bit          topic_bad;
    bit          topic_closed;
    char_t       filt_prev;
    bit          filt_started;
    bit          filt_wild;
    bit          filt_bad;
    bit          filt_miss;
    bit          filt_early;
    bit          filt_after_wild;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned live_seps();
        int unsigned n;
        int unsigned k;
        n = (shadow_count > 3'd4) ? 4 : shadow_count;
        k = 0;
        while (k < n && shadow_seps[8*k +: 8] != 8'h00)
            k++;
        return k;
    endfunction

    function automatic bit sep_hit(input char_t c);
        int unsigned n;
        n = live_seps();
        for (int k = 0; k < n; k++)
        begin
            if (shadow_seps[8*k +: 8] == c)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit wild_code(input char_t c);
        return (c == WILD_FINAL) || (c == WILD_INFIX);
    endfunction

    function automatic void clear_filter();
        topic_pos       = 0;
        filt_prev       = 8'h00;
        filt_started    = 1'b0;
        filt_wild       = 1'b0;
        filt_bad        = 1'b0;
        filt_miss       = 1'b0;
        filt_early      = 1'b0;
        filt_after_wild = 1'b0;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Advance the shadow state by one accepted transaction
    task automatic predict_verdict(input logic is_filter, input char_t c, input logic fin);
        bit          lit;
        bit          pub_ok;
        bit          bad;
        int unsigned p;
        verdict_t    v;
        if (!is_filter)
        begin
            clear_filter();
            if (topic_closed)
            begin
                topic_len    = 0;
                topic_bad    = 1'b0;
                topic_closed = 1'b0;
            end
            if (wild_code(c))
                topic_bad = 1'b1;
            if (topic_len < BUF_DEPTH)
            begin
                topic_buf[topic_len] = c;
                topic_len++;
            end
            else
                topic_bad = 1'b1;
            if (fin)
                topic_closed = 1'b1;
            return;
        end

        topic_closed = 1'b1;
        lit = filt_after_wild || !wild_code(c);

        // filter syntax
        if (!lit)
        begin
            filt_wild = 1'b1;
            if (filt_started && !sep_hit(filt_prev))
                filt_bad = 1'b1;
            if (!fin && c != WILD_INFIX)
                filt_bad = 1'b1;
        end
        else
        begin
            if (filt_after_wild && !sep_hit(c))
                filt_bad = 1'b1;
            if (fin && sep_hit(c))
                filt_bad = 1'b1;
        end

        // walk the stored topic
        if (!filt_miss && !filt_early)
        begin
            if (topic_pos >= topic_len)
                filt_miss = 1'b1;
            else if (!lit)
            begin
                p = topic_pos;
                while (p < topic_len && !sep_hit(topic_buf[p]))
                    p++;
                if (p != topic_pos)
                begin
                    topic_pos = p;
                    if (fin && (c == WILD_FINAL || topic_pos == topic_len))
                        filt_early = 1'b1;
                end
            end
            else if (topic_buf[topic_pos] != c)
                filt_miss = 1'b1;
            else
                topic_pos++;
        end

        filt_after_wild = !lit;
        filt_prev       = c;
        filt_started    = 1'b1;
        if (!fin)
            return;

        pub_ok = topic_len > 0 && !topic_bad && !sep_hit(topic_buf[topic_len - 1]);
        bad    = live_seps() == 0 || !pub_ok || filt_bad;
        v.status = bad;
        if (bad || (shadow_reject && filt_wild))
            v.match = 1'b0;
        else if (filt_early)
            v.match = 1'b1;
        else
            v.match = !filt_miss && lit && topic_pos == topic_len;
        pending_verdicts.push_back(v);
        clear_filter();
    endtask

    // Drive one character transaction and wait until it is taken
    task automatic send_char(input logic is_filter, input char_t c, input logic fin);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        op        <= is_filter;
        char_code <= c;
        last      <= fin;
        do
            @(posedge clk);
        while (busy);
        predict_verdict(is_filter, c, fin);
        items_sent++;
    endtask

    task automatic send_text(input logic is_filter, input string s, input logic fin);
        for (int k = 0; k < s.len(); k++)
            send_char(is_filter, s[k], fin && (k == s.len() - 1));
    endtask

    task automatic send_seq(input logic is_filter, input char_t s[$], input logic fin);
        for (int k = 0; k < s.size(); k++)
            send_char(is_filter, s[k], fin && (k == s.size() - 1));
    endtask

    // Hold off until every verdict is in and the block is quiet
    task automatic settle_idle();
        start <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_SEP_CHARS:   shadow_seps   = data;
            REG_SEP_COUNT:   shadow_count  = data[2:0];
            REG_REJECT_WILD: shadow_reject = data[0];
            default:         ;
        endcase
    endtask

    task automatic apply_settings(input logic [31:0] seps, input logic [2:0] count,
                                  input logic reject);
        settle_idle();
        cfg_write(REG_SEP_CHARS, seps);
        cfg_write(REG_SEP_COUNT, {29'd0, count});
        cfg_write(REG_REJECT_WILD, {31'd0, reject});
        cfg_valid <= 1'b0;
    endtask

    // Segment text: mostly a few letters so that filters hit often
    function automatic char_t pick_plain();
        char_t c;
        do
        begin
            if ($urandom_range(0, 3) != 0)
                c = char_t'(8'h61 + $urandom_range(0, 3));
            else
                c = char_t'($urandom_range(1, 255));
        end
        while (sep_hit(c) || wild_code(c));
        return c;
    endfunction

    function automatic char_t pick_sep();
        int unsigned n;
        n = live_seps();
        if (n == 0)
            return char_t'("/");
        return shadow_seps[8 * $urandom_range(0, n - 1) +: 8];
    endfunction

    // One topic followed by a few filters derived from it
    task automatic run_topic_round();
        char_t       seg_text[4][4];
        int          seg_len[4];
        char_t       seg_sep[4];
        char_t       pub[$];
        char_t       flt[$];
        int          nseg;
        int          nflt;
        int          n;
        bit          ended;
        no_idle = ($urandom_range(0, 3) == 0);
        nseg    = $urandom_range(1, 4);
        for (int i = 0; i < nseg; i++)
        begin
            if (i > 0)
                pub.push_back(seg_sep[i - 1]);
            seg_len[i] = $urandom_range(1, 4);
            for (int j = 0; j < seg_len[i]; j++)
            begin
                seg_text[i][j] = pick_plain();
                pub.push_back(seg_text[i][j]);
            end
            seg_sep[i] = pick_sep();
        end

        // break the topic now and then
        case ($urandom_range(0, 19))
            0: pub[$urandom_range(0, pub.size() - 1)] =
                   $urandom_range(0, 1) ? WILD_FINAL : WILD_INFIX;
            1: pub.push_back(pick_sep());
            2: pub.insert($urandom_range(0, pub.size()), pick_sep());
            default: ;
        endcase
        send_seq(1'b0, pub, $urandom_range(0, 19) != 0);

        nflt = $urandom_range(1, 3);
        for (int f = 0; f < nflt; f++)
        begin
            flt.delete();
            if ($urandom_range(0, 9) < 7)
            begin
                // well-formed filter with literal, '+' and '#' segments
                ended = 1'b0;
                for (int i = 0; i < nseg && !ended; i++)
                begin
                    if (i > 0)
                        flt.push_back(seg_sep[i - 1]);
                    n = $urandom_range(0, 9);
                    if (n <= 4)
                    begin
                        for (int j = 0; j < seg_len[i]; j++)
                            flt.push_back(seg_text[i][j]);
                        if ($urandom_range(0, 7) == 0)
                            flt[$urandom_range(0, flt.size() - 1)] = pick_plain();
                    end
                    else if (n <= 7)
                        flt.push_back(WILD_INFIX);
                    else
                    begin
                        flt.push_back(WILD_FINAL);
                        ended = 1'b1;
                    end
                end
                if (!ended)
                begin
                    case ($urandom_range(0, 5))
                        0:
                        begin
                            flt.push_back(pick_sep());
                            flt.push_back(pick_plain());
                        end
                        1: if (flt.size() > 1) void'(flt.pop_back());
                        default: ;
                    endcase
                end
            end
            else
            begin
                // random mix of text, separators and wildcards
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                begin
                    case ($urandom_range(0, 5))
                        3:       flt.push_back(pick_sep());
                        4:       flt.push_back(WILD_INFIX);
                        5:       flt.push_back(WILD_FINAL);
                        default: flt.push_back(pick_plain());
                    endcase
                end
            end

            if (flt.size() > 1 && $urandom_range(0, 14) == 0)
            begin
                // drop the filter midway by reloading the topic
                send_seq(1'b1, flt, 1'b0);
                send_seq(1'b0, pub, 1'b1);
            end
            else
                send_seq(1'b1, flt, 1'b1);
        end
    endtask

    task automatic test_empty_topic();
        send_text(1'b1, "a", 1'b1);
    endtask

    task automatic test_basic_matching();
        send_char(1'b0, 8'h01, 1'b0);
        send_char(1'b0, "/", 1'b0);
        send_char(1'b0, 8'hFF, 1'b1);
        send_char(1'b1, WILD_FINAL, 1'b1);
        send_char(1'b1, WILD_INFIX, 1'b0);
        send_char(1'b1, "/", 1'b0);
        send_char(1'b1, 8'hFF, 1'b1);
    endtask

    task automatic test_filter_rules();
        send_text(1'b1, "x+", 1'b1);
        send_text(1'b1, "#/", 1'b1);
        send_text(1'b1, "+x", 1'b1);
        send_text(1'b1, "x/", 1'b1);
    endtask

    task automatic test_topic_rules();
        // wildcard inside the topic
        send_text(1'b0, "+", 1'b1);
        send_text(1'b1, "+", 1'b1);
        // filter closes a topic still open
        send_text(1'b0, "x", 1'b0);
        send_text(1'b1, "x", 1'b1);
        // topic ending in a separator
        send_text(1'b0, "y/", 1'b1);
        send_text(1'b1, "y", 1'b1);
        // topic character aborts a filter in progress
        send_text(1'b0, "ab", 1'b1);
        send_text(1'b1, "a", 1'b0);
        send_text(1'b0, "q", 1'b1);
        send_text(1'b1, "q", 1'b1);
    endtask

    task automatic test_overlong_topic();
        for (int k = 0; k < BUF_DEPTH + 3; k++)
            send_char(1'b0, (k % 5 == 4) ? char_t'("/") : pick_plain(), k == BUF_DEPTH + 2);
        send_char(1'b1, WILD_INFIX, 1'b0);
        send_char(1'b1, "/", 1'b0);
        send_char(1'b1, WILD_FINAL, 1'b1);
    endtask

    task automatic test_random_traffic();
        logic [31:0] seps[7];
        logic [2:0]  counts[7];
        logic        rejects[7];
        int          target;
        seps    = '{32'h0000_2F2E, 32'h0000_2F2E, 32'hFFFF_FFFF, 32'h2B2F_3A2E,
                    32'h0000_0000, 32'h5C2F_3A2E, 32'h2D2F_3A2E};
        counts  = '{3'd2, 3'd4, 3'd4, 3'd4, 3'd1, 3'd1, 3'd3};
        rejects = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
        for (int s = 0; s < 7; s++)
        begin
            apply_settings(seps[s], counts[s], rejects[s]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                run_topic_round();
        end
    endtask

    // Check each result against the oldest expected verdict
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_verdicts.size() == 0)
                note_failure($sformatf("unexpected result status=%b match=%b", status, match));
            else
            begin
                head_verdict = pending_verdicts.pop_front();
                if (status !== head_verdict.status || match !== head_verdict.match)
                    note_failure($sformatf(
                        "verdict mismatch: expected status=%b match=%b, got status=%b match=%b",
                        head_verdict.status, head_verdict.match, status, match));
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int guard;
        rst_n     = 1'b0;
        start     = 1'b0;
        op        = 1'b0;
        char_code = 8'h00;
        last      = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_SEP_CHARS;
        cfg_data  = 32'd0;
        fail_count    = 0;
        items_sent    = 0;
        no_idle       = 1'b0;
        shadow_seps   = 32'd12078;
        shadow_count  = 3'd2;
        shadow_reject = 1'b0;
        topic_len     = 0;
        topic_bad     = 1'b0;
        topic_closed  = 1'b0;
        clear_filter();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_topic();
        test_basic_matching();
        test_filter_rules();
        test_topic_rules();
        test_overlong_topic();
        test_random_traffic();

        // drain outstanding verdicts, then let the block go quiet
        start <= 1'b0;
        guard = 0;
        while (pending_verdicts.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        fail_count += pending_verdicts.size();
        repeat (300) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
